// ===== rtl/sarc_pkg.sv =====
// Shared constants and helpers for the shortest-arc quaternion unit.
// No dependencies; imported by every module of the unit and by its checker.
package sarc_pkg;

	// input component width and Q-format fraction bits
	localparam int CB = 16;
	localparam int FB = 14;
	// width of a normalized Q2.14 component and the value 1.0
	localparam int QW = FB + 2;
	localparam int ONE = 1 << FB;
	// margin register
	localparam int MGW = 11;
	localparam logic [MGW-1:0] MARGIN_RST = MGW'(1);
	// product and product-sum widths
	localparam int PW = 2 * QW;
	localparam int DW = PW + 2;

	// cycles through one normalizer with components of width w
	function automatic int norm_lat(input int w);
		return w + 2 * FB + 6;
	endfunction

	// end-to-end latency from request to result strobe
	localparam int LAT = norm_lat(CB) + norm_lat(QW + 1) + 4;

	// round a Q6.28 sum half up to Q2.14 and saturate to +-1.0
	function automatic logic signed [QW-1:0] to_q(input logic signed [DW-1:0] p);
		logic signed [DW-1:0] r;
		r = (p + DW'(ONE / 2)) >>> FB;
		if (r > DW'(ONE))
			return QW'(ONE);
		if (r < -DW'(ONE))
			return -QW'(ONE);
		return QW'(r);
	endfunction

endpackage

// ===== rtl/sarc_norm.sv =====
// Pipelined vector normalizer: bit-per-stage square root, then a
// bit-per-stage divider per lane. Depends on sarc_pkg.
module sarc_norm #(
	parameter int W  = sarc_pkg::CB,
	parameter int SW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [W-1:0]           vec [3],
	input  logic [SW-1:0]                 side_in,
	output logic                          out_valid,
	output logic signed [sarc_pkg::QW-1:0] unit [3],
	output logic                          zero,
	output logic [SW-1:0]                 side_out
);
	import sarc_pkg::*;

	localparam int LW  = 2 * W;
	localparam int NW  = LW + 2 * FB;
	localparam int RW  = NW / 2;
	localparam int RMW = RW + 2;
	localparam int QB  = FB + 2;
	localparam int CW  = W + 2 * FB + 2;
	localparam int PYW = SW + 3 + 3 * W;

	logic [W-1:0] mag [3];
	logic         v_s1;
	logic [W-1:0] m_s1 [3];
	logic [2:0]   sg_s1;
	logic [LW-1:0] sq_s1 [3];
	logic [SW-1:0] sd_s1;

	logic           sqv [0:RW];
	logic [LW-1:0]  sql [0:RW];
	logic [RMW-1:0] sqr [0:RW];
	logic [RW-1:0]  sqt [0:RW];
	logic [PYW-1:0] sqp [0:RW];

	logic           dvv [0:QB];
	logic [RW-1:0]  dvs [0:QB];
	logic [PYW-1:0] dvp [0:QB];
	logic [CW-1:0]  dvr [0:QB][3];
	logic [QB-1:0]  dvq [0:QB][3];

	logic [QB-1:0]        qm [3];
	logic signed [QW-1:0] nn [3];
	logic                 zf;

	// take magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++)
			mag[i] = vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
	end

	// stage 1: square each magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s1[i]  <= mag[i];
			sg_s1[i] <= vec[i][W-1];
			sq_s1[i] <= LW'(mag[i]) * LW'(mag[i]);
		end
		sd_s1 <= side_in;
	end

	// stage 2: sum to squared length, seed the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv[0] <= 1'b0;
		end else begin
			sqv[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sql[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		sqr[0] <= '0;
		sqt[0] <= '0;
		sqp[0] <= {sd_s1, sg_s1, m_s1[2], m_s1[1], m_s1[0]};
	end

	// square root of len2 * 2^(2*FB), one result bit per stage
	for (genvar k = 0; k < RW; k++) begin : g_sq
		logic [NW-1:0]  num;
		logic [RMW-1:0] rin;
		logic [RMW-1:0] trial;
		logic           take;

		assign num   = {sql[k], {(2 * FB){1'b0}}};
		assign rin   = {sqr[k][RW-1:0], num[NW-1-2*k -: 2]};
		assign trial = {sqt[k], 2'b01};
		assign take  = rin >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv[k+1] <= 1'b0;
			end else begin
				sqv[k+1] <= sqv[k];
			end
		end

		always_ff @(posedge clk) begin
			sql[k+1] <= sql[k];
			sqp[k+1] <= sqp[k];
			sqr[k+1] <= take ? rin - trial : rin;
			sqt[k+1] <= {sqt[k][RW-2:0], take};
		end
	end

	// load dividends with rounding half of the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv[0] <= 1'b0;
		end else begin
			dvv[0] <= sqv[RW];
		end
	end

	always_ff @(posedge clk) begin
		dvs[0] <= sqt[RW];
		dvp[0] <= sqp[RW];
		for (int l = 0; l < 3; l++) begin
			dvr[0][l] <= (CW'(sqp[RW][l*W +: W]) << (2 * FB)) + CW'(sqt[RW] >> 1);
			dvq[0][l] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_dv
		localparam int SH = QB - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv[j+1] <= 1'b0;
			end else begin
				dvv[j+1] <= dvv[j];
			end
		end

		always_ff @(posedge clk) begin
			dvs[j+1] <= dvs[j];
			dvp[j+1] <= dvp[j];
		end

		for (genvar l = 0; l < 3; l++) begin : g_ln
			logic [CW-1:0] dsr;
			logic          take;

			assign dsr  = CW'(dvs[j]) << SH;
			assign take = dvr[j][l] >= dsr;

			always_ff @(posedge clk) begin
				dvr[j+1][l] <= take ? dvr[j][l] - dsr : dvr[j][l];
				dvq[j+1][l] <= {dvq[j][l][QB-2:0], take};
			end
		end
	end

	// saturate and restore signs
	assign zf = dvs[QB] == '0;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qm[l] = (dvq[QB][l] > QB'(ONE)) ? QB'(ONE) : dvq[QB][l];
			nn[l] = dvp[QB][3*W + l] ? -signed'(QW'(qm[l])) : signed'(QW'(qm[l]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= dvv[QB];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++)
			unit[l] <= zf ? '0 : nn[l];
		zero     <= zf;
		side_out <= dvp[QB][PYW-1 -: SW];
	end

endmodule

// ===== rtl/shortest_arc_quaternion_unit.sv =====
// Shortest-arc quaternion unit: takes one vector pair per clock and returns
// the Q2.14 rotation quaternion. Fixed latency, one result per request, in
// request order. busy stays low and cfg_ready stays high;
// results are strobed by done for one cycle and cannot be held off, so the
// receiver must take each one as it comes. The latency is set by two chained
// normalizers (u and v side by side, then the halfway or axis vector), each a
// bit-per-stage square root followed by a bit-per-stage divider.
// Depends on sarc_pkg and sarc_norm.
module shortest_arc_quaternion_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [sarc_pkg::CB-1:0] from_x,
	input  logic signed [sarc_pkg::CB-1:0] from_y,
	input  logic signed [sarc_pkg::CB-1:0] from_z,
	input  logic signed [sarc_pkg::CB-1:0] to_x,
	input  logic signed [sarc_pkg::CB-1:0] to_y,
	input  logic signed [sarc_pkg::CB-1:0] to_z,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sarc_pkg::MGW-1:0]     cfg_data,
	output logic                         done,
	output logic signed [sarc_pkg::QW-1:0] quat_x,
	output logic signed [sarc_pkg::QW-1:0] quat_y,
	output logic signed [sarc_pkg::QW-1:0] quat_z,
	output logic signed [sarc_pkg::QW-1:0] quat_w,
	output logic                         opposite_case,
	output logic                         zero_input
);
	import sarc_pkg::*;

	localparam int SWD = QW + 1;
	localparam int HSW = 2 + 3 * QW;

	logic [MGW-1:0] margin_q;

	logic signed [CB-1:0] vu [3];
	logic signed [CB-1:0] vv [3];
	logic                 nu_v, nu_z, nv_z;
	logic signed [QW-1:0] nu [3];
	logic signed [QW-1:0] nv [3];

	logic                  v_s1, zero_s1;
	logic signed [QW-1:0]  u_s1 [3];
	logic signed [SWD-1:0] s_s1 [3];
	logic signed [PW-1:0]  pr_s1 [3];

	logic signed [DW-1:0]  dot, thr;
	logic                  s_zero, opp;
	logic [QW-1:0]         au [3];
	logic                  pick_x, pick_y;
	logic signed [SWD-1:0] t [3];
	logic signed [SWD-1:0] nu_neg [3];

	logic                  v_s2;
	logic signed [SWD-1:0] c_s2 [3];
	logic [HSW-1:0]        sd_s2;

	logic                  nh_v;
	logic signed [QW-1:0]  nh [3];
	logic [HSW-1:0]        nh_sd;

	logic                  v_s3, opp_s3, zero_s3;
	logic signed [QW-1:0]  h_s3 [3];
	logic signed [PW-1:0]  pm_s3 [3][3];

	logic signed [DW-1:0]  cx, cy, cz, cw;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// hold the margin register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			margin_q <= cfg_data;
		end
	end

	// normalize u and v side by side
	assign vu[0] = from_x;
	assign vu[1] = from_y;
	assign vu[2] = from_z;
	assign vv[0] = to_x;
	assign vv[1] = to_y;
	assign vv[2] = to_z;

	sarc_norm #(.W(CB), .SW(1)) u_norm_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.vec      (vu),
		.side_in  (1'b0),
		.out_valid(nu_v),
		.unit     (nu),
		.zero     (nu_z),
		.side_out ()
	);

	sarc_norm #(.W(CB), .SW(1)) u_norm_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.vec      (vv),
		.side_in  (1'b0),
		.out_valid(),
		.unit     (nv),
		.zero     (nv_z),
		.side_out ()
	);

	// stage 1: dot-product terms and u+v
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= nu_v;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= nu_z || nv_z;
		for (int i = 0; i < 3; i++) begin
			u_s1[i]  <= nu[i];
			s_s1[i]  <= SWD'(nu[i]) + SWD'(nv[i]);
			pr_s1[i] <= PW'(nu[i]) * PW'(nv[i]);
		end
	end

	// opposite test against the margin threshold
	assign dot    = DW'(pr_s1[0]) + DW'(pr_s1[1]) + DW'(pr_s1[2]);
	assign thr    = (signed'(DW'(margin_q)) - DW'(ONE)) <<< FB;
	assign s_zero = (s_s1[0] == '0) && (s_s1[1] == '0) && (s_s1[2] == '0);
	assign opp    = !zero_s1 && ((dot <= thr) || s_zero);

	// orthogonal axis: cross u with the axis of its smallest component
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			au[i]     = u_s1[i][QW-1] ? QW'(-u_s1[i]) : QW'(u_s1[i]);
			nu_neg[i] = -SWD'(u_s1[i]);
		end
		pick_x = (au[0] < au[1]) && (au[0] < au[2]);
		pick_y = !(au[0] < au[1]) && (au[1] < au[2]);
		if (pick_x) begin
			t[0] = '0;
			t[1] = SWD'(u_s1[2]);
			t[2] = nu_neg[1];
		end else if (pick_y) begin
			t[0] = nu_neg[2];
			t[1] = '0;
			t[2] = SWD'(u_s1[0]);
		end else begin
			t[0] = SWD'(u_s1[1]);
			t[1] = nu_neg[0];
			t[2] = '0;
		end
	end

	// stage 2: choose the vector to normalize next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			c_s2[i] <= opp ? t[i] : s_s1[i];
		sd_s2 <= {zero_s1, opp, u_s1[2], u_s1[1], u_s1[0]};
	end

	sarc_norm #(.W(SWD), .SW(HSW)) u_norm_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.vec      (c_s2),
		.side_in  (sd_s2),
		.out_valid(nh_v),
		.unit     (nh),
		.zero     (),
		.side_out (nh_sd)
	);

	// stage 3: all products of u and h
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= nh_v;
		end
	end

	always_ff @(posedge clk) begin
		zero_s3 <= nh_sd[HSW-1];
		opp_s3  <= nh_sd[HSW-2];
		for (int i = 0; i < 3; i++) begin
			h_s3[i] <= nh[i];
			for (int j = 0; j < 3; j++)
				pm_s3[i][j] <= PW'(signed'(nh_sd[i*QW +: QW])) * PW'(nh[j]);
		end
	end

	// cross and dot of u and h
	assign cx = DW'(pm_s3[1][2]) - DW'(pm_s3[2][1]);
	assign cy = DW'(pm_s3[2][0]) - DW'(pm_s3[0][2]);
	assign cz = DW'(pm_s3[0][1]) - DW'(pm_s3[1][0]);
	assign cw = DW'(pm_s3[0][0]) + DW'(pm_s3[1][1]) + DW'(pm_s3[2][2]);

	// stage 4: select, round and drive the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s3) begin
			quat_x <= '0;
			quat_y <= '0;
			quat_z <= '0;
			quat_w <= '0;
		end else if (opp_s3) begin
			quat_x <= h_s3[0];
			quat_y <= h_s3[1];
			quat_z <= h_s3[2];
			quat_w <= '0;
		end else begin
			quat_x <= to_q(cx);
			quat_y <= to_q(cy);
			quat_z <= to_q(cz);
			quat_w <= to_q(cw);
		end
		opposite_case <= opp_s3;
		zero_input    <= zero_s3;
	end

endmodule

// ===== rtl/sarc_chk.sv =====
// Port-level checker for the shortest-arc quaternion unit, bound to the top.
// Depends on sarc_pkg and shortest_arc_quaternion_unit.
module sarc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic signed [sarc_pkg::QW-1:0] quat_x,
	input logic signed [sarc_pkg::QW-1:0] quat_y,
	input logic signed [sarc_pkg::QW-1:0] quat_z,
	input logic signed [sarc_pkg::QW-1:0] quat_w,
	input logic                          opposite_case,
	input logic                          zero_input
);
	import sarc_pkg::*;

	// every result traces back to a request a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching request");

	// a zero-length input yields an all-zero result
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_input |-> quat_x == '0 && quat_y == '0 && quat_z == '0
			&& quat_w == '0 && !opposite_case)
		else $error("zero input gave nonzero result");

	// a half turn has no scalar part
	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		done && opposite_case |-> quat_w == '0)
		else $error("half turn with nonzero w");

endmodule

bind shortest_arc_quaternion_unit sarc_chk u_sarc_chk (.*);
